FILE: hdl/http_header_line_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// http header line parser assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_UNIT_DEFINES_SVH
`define HTTP_HEADER_LINE_PARSER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define HHLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// property checked on every clock edge, reset included
`define HHLP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// types, constants and name tables shared by the header line parser
// ----------------------------------------------------------------------------
package hhlp_pkg;

	// block geometry
	localparam int BLOCK_BYTES = 4096;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int POS_MAX     = BLOCK_BYTES - 1;
	localparam int OFS_W       = 12;
	localparam int EXT_W       = (POS_W + 1 > OFS_W) ? POS_W + 1 : OFS_W;
	localparam int NUM_W       = 32;
	localparam int IDX_W       = 4;
	localparam int CHARS_W     = 5;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// header name table
	localparam int NAME_COUNT   = 12;
	localparam int NAME_MAX_LEN = 19;
	localparam int NAME_W       = 8 * NAME_MAX_LEN;

	localparam logic [IDX_W-1:0] IDX_CONTENT_LENGTH = 4'd0;
	localparam logic [IDX_W-1:0] IDX_STATUS         = 4'd8;

	// names are right aligned: last character in the low byte
	localparam logic [NAME_W-1:0] NAME_TABLE [NAME_COUNT] = '{
		NAME_W'("Content-Length: "),
		NAME_W'("Content-Type:"),
		NAME_W'("User-Agent: "),
		NAME_W'("If-Modified-Since: "),
		NAME_W'("Authorization: "),
		NAME_W'("Referer: "),
		NAME_W'("Cookie:"),
		NAME_W'("Location: "),
		NAME_W'("Status: "),
		NAME_W'("Range: "),
		NAME_W'("Connection: "),
		NAME_W'("Transfer-Encoding: ")
	};

	localparam logic [CHARS_W-1:0] NAME_LEN [NAME_COUNT] = '{
		5'd16, 5'd13, 5'd12, 5'd19, 5'd15, 5'd9,
		5'd7,  5'd10, 5'd8,  5'd7,  5'd12, 5'd19
	};

	// character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic             line_matched;
		logic [IDX_W-1:0] header_index;
		logic [OFS_W-1:0] value_offset;
		logic [OFS_W-1:0] value_length;
		logic             is_numeric;
		logic [NUM_W-1:0] number_value;
		logic             end_of_block;
	} out_item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             feed;
		logic             emit;
		logic             matched;
		logic [IDX_W-1:0] index;
		logic [OFS_W-1:0] offset;
		logic [OFS_W-1:0] length;
		logic             last;
	} rec_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	// character idx of name k, zero past its end
	function automatic logic [7:0] name_char(input logic [IDX_W-1:0] k,
			input logic [CHARS_W-1:0] idx);
		logic [CHARS_W-1:0] rel;
		logic [7:0]         ch;
		ch = 8'h00;
		if (idx < NAME_LEN[k]) begin
			rel = NAME_LEN[k] - 5'd1 - idx;
			ch  = NAME_TABLE[k][8*rel +: 8];
		end
		return ch;
	endfunction

	// byte positions saturate at the block end
	function automatic logic [EXT_W-1:0] clamp_pos(input logic [EXT_W-1:0] p);
		return (p > EXT_W'(POS_MAX)) ? EXT_W'(POS_MAX) : p;
	endfunction

endpackage

FILE: hdl/hhlp_front.sv
// ----------------------------------------------------------------------------
// hhlp_front
// accepts header bytes, matches line starts against the name table and
// tracks positions; hands feed and line end records to the queue
// ----------------------------------------------------------------------------
module hhlp_front import hhlp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  in_item_t byte_data,
	input  q_flags_t q_flags,
	output logic     push,
	output rec_t     push_rec
);

	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      lstart_q;
	logic [CHARS_W-1:0]    chars_q;
	logic [NAME_COUNT-1:0] cand_q;
	logic                  matched_q;
	logic [IDX_W-1:0]      midx_q;
	logic                  prevcr_q;

	logic                  accept;
	logic [7:0]            c;
	logic                  last;
	logic                  nl;
	logic                  is_cr;
	logic [NAME_COUNT-1:0] hit;
	logic [NAME_COUNT-1:0] done;
	logic [IDX_W-1:0]      first;
	logic                  match_now;
	logic                  matched_n;
	logic [IDX_W-1:0]      midx_n;
	logic [NAME_COUNT-1:0] cand_n;
	logic                  feed;
	logic                  emit;
	logic [CHARS_W-1:0]    nlen;
	logic [POS_W:0]        pos_inc;
	logic [POS_W-1:0]      pos_next;
	logic [EXT_W-1:0]      vs;
	logic [EXT_W-1:0]      stop_p;
	logic [EXT_W-1:0]      len_v;
	logic                  cr;

	assign byte_stall = q_flags.full;
	assign accept     = byte_valid && !q_flags.full;
	assign c          = byte_data.data_byte;
	assign last       = byte_data.last_byte;
	assign nl         = (c == CH_LF);
	assign is_cr      = (c == CH_CR);

	// per-name compare at the current line column
	always_comb begin
		hit   = '0;
		done  = '0;
		first = '0;
		for (int k = 0; k < NAME_COUNT; k++) begin
			hit[k]  = cand_q[k] && (chars_q < NAME_LEN[k]) &&
				(name_char(IDX_W'(k), chars_q) == c);
			done[k] = hit[k] && ((chars_q + 5'd1) == NAME_LEN[k]);
		end
		for (int k = NAME_COUNT - 1; k >= 0; k--) begin
			if (done[k]) first = IDX_W'(k);
		end
	end

	// match bookkeeping
	always_comb begin
		match_now = !matched_q && !nl && (|done) && !last;
		matched_n = matched_q || match_now;
		midx_n    = match_now ? first : midx_q;
		if (!matched_q && !nl) begin
			cand_n = (|done) ? '0 : hit;
		end else if (nl) begin
			cand_n = '0;
		end else begin
			cand_n = cand_q;
		end
		feed = matched_q && !nl &&
			((midx_q == IDX_CONTENT_LENGTH) || (midx_q == IDX_STATUS));
		emit = nl || last;
	end

	// positions and value span
	always_comb begin
		pos_inc  = {1'b0, pos_q} + (POS_W+1)'(1);
		pos_next = (pos_inc > (POS_W+1)'(POS_MAX)) ? POS_W'(POS_MAX) : pos_inc[POS_W-1:0];
		nlen     = (midx_n < NAME_COUNT) ? NAME_LEN[midx_n] : '0;
		vs       = clamp_pos(EXT_W'(lstart_q) + EXT_W'(nlen));
		stop_p   = clamp_pos(nl ? EXT_W'(pos_q) : EXT_W'(pos_q) + EXT_W'(1));
		len_v    = (stop_p >= vs) ? stop_p - vs : '0;
		cr       = nl ? prevcr_q : is_cr;
		if (cr && (len_v != '0)) len_v = len_v - EXT_W'(1);
	end

	// record for the back end
	always_comb begin
		push_rec.data_byte = c;
		push_rec.feed      = feed;
		push_rec.emit      = emit;
		push_rec.last      = last;
		push_rec.matched   = matched_n;
		push_rec.index     = matched_n ? midx_n : '0;
		push_rec.offset    = matched_n ? vs[OFS_W-1:0] : '0;
		push_rec.length    = matched_n ? len_v[OFS_W-1:0] : '0;
		push               = accept && (feed || emit);
	end

	// line and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			lstart_q  <= '0;
			chars_q   <= '0;
			cand_q    <= '1;
			matched_q <= 1'b0;
			midx_q    <= '0;
			prevcr_q  <= 1'b0;
		end else if (accept) begin
			if (emit) begin
				chars_q   <= '0;
				cand_q    <= '1;
				matched_q <= 1'b0;
				midx_q    <= '0;
				prevcr_q  <= 1'b0;
				if (last) begin
					pos_q    <= '0;
					lstart_q <= '0;
				end else begin
					pos_q    <= pos_next;
					lstart_q <= pos_next;
				end
			end else begin
				pos_q     <= pos_next;
				cand_q    <= cand_n;
				matched_q <= matched_n;
				midx_q    <= midx_n;
				prevcr_q  <= is_cr;
				if (chars_q != '1) chars_q <= chars_q + 5'd1;
			end
		end
	end

endmodule

FILE: hdl/hhlp_queue.sv
// ----------------------------------------------------------------------------
// hhlp_queue
// short register queue that decouples classification from number parsing
// ----------------------------------------------------------------------------
module hhlp_queue import hhlp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rec_t     push_rec,
	input  logic     pop,
	output rec_t     pop_rec,
	output q_flags_t q_flags
);

	rec_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_flags.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign q_flags.empty = (cnt_q == '0);
	assign do_push       = push && !q_flags.full;
	assign do_pop        = pop && !q_flags.empty;
	assign pop_rec       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/hhlp_back.sv
// ----------------------------------------------------------------------------
// hhlp_back
// parses decimal values from queued records and builds line results
// through a pending stage and the output register
// ----------------------------------------------------------------------------
module hhlp_back import hhlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rec_t      q_rec,
	input  q_flags_t  q_flags,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	localparam logic [1:0] PH_BLANK  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	typedef struct packed {
		logic             matched;
		logic [IDX_W-1:0] index;
		logic [OFS_W-1:0] offset;
		logic [OFS_W-1:0] length;
		logic             is_numeric;
		logic             has_number;
		logic [NUM_W-1:0] acc;
		logic             neg;
		logic             ovf;
		logic             last;
	} pend_t;

	logic [NUM_W-1:0] acc_q;
	logic [1:0]       phase_q;
	logic             neg_q;
	logic             ovf_q;

	logic             s1_v_q;
	pend_t            pend_s1;
	logic             out_v_q;
	out_item_t        out_q;

	logic             out_free;
	logic             s1_adv;
	logic             s1_free;
	logic [7:0]       c;
	logic             digit;
	logic             blank;
	logic [3:0]       d;
	logic [NUM_W+3:0] sum;
	logic [NUM_W-1:0] acc_n;
	logic [1:0]       phase_n;
	logic             neg_n;
	logic             ovf_n;
	pend_t            pend_n;

	// pipeline flow
	assign out_free = !out_v_q || !result_stall;
	assign s1_adv   = s1_v_q && out_free;
	assign s1_free  = !s1_v_q || out_free;
	assign pop      = !q_flags.empty && (!q_rec.emit || s1_free);

	assign c     = q_rec.data_byte;
	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) ||
		(c == CH_FF) || (c == CH_CR);
	assign d     = c[3:0];
	assign sum   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + (NUM_W+4)'(d);

	// number parse step
	always_comb begin
		acc_n   = acc_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		ovf_n   = ovf_q;
		if (q_rec.feed) begin
			case (phase_q)
				PH_BLANK, PH_SIGN: begin
					if (phase_q == PH_BLANK && blank) begin
						phase_n = PH_BLANK;
					end else if (phase_q == PH_BLANK && c == CH_PLUS) begin
						phase_n = PH_SIGN;
					end else if (phase_q == PH_BLANK && c == CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGN;
					end else if (digit) begin
						acc_n   = NUM_W'(d);
						phase_n = PH_DIGITS;
					end else begin
						acc_n   = '0;
						neg_n   = 1'b0;
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (!digit) begin
						phase_n = PH_DONE;
					end else if (sum[NUM_W+3:NUM_W] != 4'd0) begin
						ovf_n = 1'b1;
					end else begin
						acc_n = sum[NUM_W-1:0];
					end
				end
				default: phase_n = phase_q;
			endcase
		end
	end

	// pending result from a line end record
	always_comb begin
		pend_n.matched    = q_rec.matched;
		pend_n.index      = q_rec.index;
		pend_n.offset     = q_rec.offset;
		pend_n.length     = q_rec.length;
		pend_n.is_numeric = q_rec.matched &&
			((q_rec.index == IDX_CONTENT_LENGTH) || (q_rec.index == IDX_STATUS));
		pend_n.has_number = pend_n.is_numeric && (phase_n[1] == 1'b1);
		pend_n.acc        = acc_n;
		pend_n.neg        = neg_n;
		pend_n.ovf        = ovf_n;
		pend_n.last       = q_rec.last;
	end

	// number state, cleared at every line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			if (q_rec.emit) begin
				acc_q   <= '0;
				phase_q <= PH_BLANK;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				acc_q   <= acc_n;
				phase_q <= phase_n;
				neg_q   <= neg_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && q_rec.emit) s1_v_q <= 1'b1;
			else if (s1_adv) s1_v_q <= 1'b0;
			if (s1_adv) out_v_q <= 1'b1;
			else if (out_v_q && !result_stall) out_v_q <= 1'b0;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (pop && q_rec.emit) pend_s1 <= pend_n;
		if (s1_adv) begin
			out_q.line_matched <= pend_s1.matched;
			out_q.header_index <= pend_s1.index;
			out_q.value_offset <= pend_s1.offset;
			out_q.value_length <= pend_s1.length;
			out_q.is_numeric   <= pend_s1.is_numeric;
			out_q.end_of_block <= pend_s1.last;
			if (!pend_s1.has_number) out_q.number_value <= '0;
			else if (pend_s1.ovf) out_q.number_value <= '1;
			else if (pend_s1.neg) out_q.number_value <= NUM_W'(0) - pend_s1.acc;
			else out_q.number_value <= pend_s1.acc;
		end
	end

	assign result_valid = out_v_q;
	assign result_data  = out_q;

endmodule

FILE: hdl/http_header_line_parser_unit.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_unit
// splits a header block into lines and reports known headers and values
// ----------------------------------------------------------------------------
// usage:
//   byte channel: one header byte per transaction, last_byte marks the end of
//   the block. result channel: one transaction per newline or last byte,
//   with the header index, value span and, for Content-Length and Status,
//   the decimal value saturated at all ones.
//   throughput is one byte per cycle while the queue is not full; the name
//   compare over all twelve names and the decimal multiply-add are each
//   combinational. a line end byte passes through the queue, the pending
//   stage and then the output register on its way to result_valid.
//   a four-entry queue separates the classifier from the number parser, so
//   a stalled result keeps the classifier taking bytes until the queue
//   fills; byte_stall rises only when the queue is full.
//   reset clears all line and block state and empties the queue and the
//   result stages; no clearing pass is needed. after the last byte the
//   block state returns to its reset value.
// ----------------------------------------------------------------------------
module http_header_line_parser_unit import hhlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_data,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	q_flags_t q_flags;
	logic     push;
	rec_t     push_rec;
	logic     pop;
	rec_t     pop_rec;

	// byte classification and name matching
	hhlp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_flags    (q_flags),
		.push       (push),
		.push_rec   (push_rec)
	);

	// decoupling queue
	hhlp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.q_flags  (q_flags)
	);

	// number parse and result output
	hhlp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rec        (pop_rec),
		.q_flags      (q_flags),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

FILE: hdl/hhlp_checker.sv
// ----------------------------------------------------------------------------
// hhlp_checker
// port level assertions for the header line parser, bound to the top level
// ----------------------------------------------------------------------------
`include "http_header_line_parser_unit_defines.svh"

module hhlp_checker import hhlp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      byte_valid,
	input logic      byte_stall,
	input in_item_t  byte_data,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result_data
);

	// no result while reset is applied
	`HHLP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !result_valid, "result valid in reset")

	// a stalled result holds
	`HHLP_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result_data), "stalled result changed")

	// an unmatched line reports only the block end flag
	`HHLP_ASSERT(a_unmatched_zero, result_valid && !result_data.line_matched |-> (result_data.header_index == 4'd0) && (result_data.value_offset == 12'd0) && (result_data.value_length == 12'd0) && !result_data.is_numeric && (result_data.number_value == 32'd0), "unmatched line with nonzero fields")

	// numeric flag follows the header index
	`HHLP_ASSERT(a_numeric_index, result_valid && result_data.line_matched |-> (result_data.header_index < NAME_COUNT) && (result_data.is_numeric == ((result_data.header_index == IDX_CONTENT_LENGTH) || (result_data.header_index == IDX_STATUS))), "numeric flag does not match header index")

	// only numeric headers carry a number
	`HHLP_ASSERT(a_number_only_numeric, result_valid && !result_data.is_numeric |-> (result_data.number_value == 32'd0), "number on non-numeric header")

endmodule

bind http_header_line_parser_unit hhlp_checker u_checker (.*);

FILE: tb/sv/header_result_checker.sv
// ----------------------------------------------------------------------------
// header_result_checker
// watches both channels of the header line parser, predicts each line report
// from the accepted bytes and compares every result field by field
// ----------------------------------------------------------------------------
module header_result_checker import hhlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_stall,
	input  in_item_t  byte_data,
	input  logic      result_valid,
	input  logic      result_stall,
	input  out_item_t result_data,
	output int        errors,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [12:0] POS_LAST = 13'd4095;

	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_SIGN,
		NUM_DIGITS,
		NUM_STOP
	} num_phase_t;

	// line reports still owed by the block, oldest first
	out_item_t expected_lines [$];
	int        mismatches = 0;

	// predicted block and line state
	logic [11:0] byte_pos;
	logic [11:0] line_begin;
	logic [4:0]  line_chars;
	logic [11:0] live_names;
	logic        name_hit;
	logic [3:0]  hit_index;
	logic [31:0] num_acc;
	num_phase_t  num_phase;
	logic        num_neg;
	logic        num_ovf;
	logic        prev_cr;

	// known header names in table order
	function automatic string header_name(input int k);
		case (k)
			0:       return "Content-Length: ";
			1:       return "Content-Type:";
			2:       return "User-Agent: ";
			3:       return "If-Modified-Since: ";
			4:       return "Authorization: ";
			5:       return "Referer: ";
			6:       return "Cookie:";
			7:       return "Location: ";
			8:       return "Status: ";
			9:       return "Range: ";
			10:      return "Connection: ";
			default: return "Transfer-Encoding: ";
		endcase
	endfunction

	// positions stop at the last byte of the block
	function automatic logic [12:0] sat_pos(input logic [12:0] p);
		return (p > POS_LAST) ? POS_LAST : p;
	endfunction

	function automatic void clear_line();
		line_chars = '0;
		live_names = '1;
		name_hit   = 1'b0;
		hit_index  = '0;
		num_acc    = '0;
		num_phase  = NUM_SKIP;
		num_neg    = 1'b0;
		num_ovf    = 1'b0;
		prev_cr    = 1'b0;
	endfunction

	// decimal value in the manner of strtoul, saturating on overflow
	function automatic void feed_number(input logic [7:0] c);
		logic        digit;
		logic        blank;
		logic [31:0] d;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
			(c == CH_CR);
		d = {24'd0, c} - {24'd0, CH_ZERO};
		case (num_phase)
			NUM_SKIP, NUM_SIGN: begin
				if (num_phase == NUM_SKIP && blank) begin
				end else if (num_phase == NUM_SKIP && c == CH_PLUS) begin
					num_phase = NUM_SIGN;
				end else if (num_phase == NUM_SKIP && c == CH_MINUS) begin
					num_neg   = 1'b1;
					num_phase = NUM_SIGN;
				end else if (digit) begin
					num_acc   = d;
					num_phase = NUM_DIGITS;
				end else begin
					num_acc   = '0;
					num_neg   = 1'b0;
					num_phase = NUM_STOP;
				end
			end
			NUM_DIGITS: begin
				if (!digit)
					num_phase = NUM_STOP;
				else if (num_acc > (32'hFFFF_FFFF - d) / 32'd10)
					num_ovf = 1'b1;
				else
					num_acc = num_acc * 32'd10 + d;
			end
			default: begin
			end
		endcase
	endfunction

	// advance the predicted state by one byte, report at a line end
	function automatic logic predict_line_report(input in_item_t it, output out_item_t rpt);
		logic [7:0]  c;
		logic        fin_byte;
		logic        nl;
		logic [12:0] cur;
		logic [12:0] vs;
		logic [12:0] stop_pos;
		logic [12:0] len;
		logic        was_hit;
		logic        cr;
		logic        numeric;
		logic        done;
		string       nm;
		int          k;
		c        = it.data_byte;
		fin_byte = it.last_byte;
		nl       = (c == CH_LF);
		cur      = {1'b0, byte_pos};
		was_hit  = name_hit;
		rpt      = '0;

		// name compare against every live candidate
		if (!name_hit && !nl) begin
			done = 1'b0;
			for (k = 0; k < NAME_COUNT; k++) begin
				if (!done && live_names[k]) begin
					nm = header_name(k);
					if (line_chars >= nm.len() || nm[line_chars] != c) begin
						live_names[k] = 1'b0;
					end else if (line_chars + 1 == nm.len()) begin
						live_names = '0;
						if (!fin_byte) begin
							name_hit  = 1'b1;
							hit_index = 4'(k);
						end
						done = 1'b1;
					end
				end
			end
		end else if (nl) begin
			live_names = '0;
		end

		if (was_hit && !nl && (hit_index == IDX_CONTENT_LENGTH || hit_index == IDX_STATUS))
			feed_number(c);

		// line end: describe the line and start the next one
		if (nl || fin_byte) begin
			if (name_hit) begin
				nm       = header_name(hit_index);
				vs       = sat_pos({1'b0, line_begin} + 13'(nm.len()));
				stop_pos = sat_pos(nl ? cur : cur + 13'd1);
				len      = (stop_pos >= vs) ? stop_pos - vs : 13'd0;
				cr       = nl ? prev_cr : (c == CH_CR);
				numeric  = (hit_index == IDX_CONTENT_LENGTH) || (hit_index == IDX_STATUS);
				if (cr && len > 0)
					len = len - 13'd1;
				rpt.line_matched = 1'b1;
				rpt.header_index = hit_index;
				rpt.value_offset = vs[11:0];
				rpt.value_length = len[11:0];
				rpt.is_numeric   = numeric;
				if (numeric && num_phase >= NUM_DIGITS)
					rpt.number_value = num_ovf ? 32'hFFFF_FFFF :
						(num_neg ? 32'd0 - num_acc : num_acc);
			end
			rpt.end_of_block = fin_byte;
			clear_line();
			if (fin_byte) begin
				byte_pos   = '0;
				line_begin = '0;
			end else begin
				stop_pos   = sat_pos(cur + 13'd1);
				byte_pos   = stop_pos[11:0];
				line_begin = byte_pos;
			end
			return 1'b1;
		end

		stop_pos = sat_pos(cur + 13'd1);
		byte_pos = stop_pos[11:0];
		if (line_chars < 5'd31)
			line_chars = line_chars + 5'd1;
		prev_cr = (c == CH_CR);
		return 1'b0;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// predict on each byte transaction, compare on each result transaction
	always @(posedge clk or negedge arst_n) begin
		out_item_t rpt;
		out_item_t want;
		if (!arst_n) begin
			byte_pos   = '0;
			line_begin = '0;
			clear_line();
			expected_lines.delete();
		end else begin
			if (byte_valid && !byte_stall) begin
				if (predict_line_report(byte_data, rpt))
					expected_lines.push_back(rpt);
			end
			if (result_valid && !result_stall) begin
				if (expected_lines.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, result_data);
					mismatches++;
				end else begin
					want = expected_lines.pop_front();
					check_field("line_matched", want.line_matched, result_data.line_matched);
					check_field("header_index", want.header_index, result_data.header_index);
					check_field("value_offset", want.value_offset, result_data.value_offset);
					check_field("value_length", want.value_length, result_data.value_length);
					check_field("is_numeric", want.is_numeric, result_data.is_numeric);
					check_field("number_value", want.number_value, result_data.number_value);
					check_field("end_of_block", want.end_of_block, result_data.end_of_block);
				end
			end
		end
		errors      <= mismatches;
		outstanding <= expected_lines.size();
	end

endmodule

FILE: tb/sv/http_header_line_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// http_header_line_parser_unit_tb
// drives header blocks built from known names, numbers, broken names and
// noise into the parser with bursty input and a patterned result stall
// ----------------------------------------------------------------------------
module http_header_line_parser_unit_tb;
	import hhlp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_BYTES = 1000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b1;
	logic      byte_valid   = 1'b0;
	in_item_t  byte_data    = '0;
	logic      result_stall = 1'b0;
	logic      byte_stall;
	logic      result_valid;
	out_item_t result_data;

	int fail_count;
	int awaiting;
	int cycle_count = 0;
	int burst_left  = 0;
	int bytes_sent  = 0;
	int blocks_sent = 0;

	// bytes of the block being assembled
	logic [7:0] pending [$];

	http_header_line_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	header_result_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.errors       (fail_count),
		.outstanding  (awaiting)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("http_header_line_parser_unit regression: fail");
			$finish;
		end
	end

	// result stall pattern, switching between modes
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          run_left   = 0;
	int          phase_cnt  = 0;
	logic        run_hold   = 1'b0;
	logic        hold;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(50, 400);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:     hold = 1'b0;
				STALL_RANDOM:   hold = ($urandom_range(0, 2) == 0);
				STALL_PERIODIC: hold = ((phase_cnt % 11) >= 6);
				default: begin
					if (run_left == 0) begin
						run_hold = !run_hold;
						run_left = run_hold ? $urandom_range(1, 20) : $urandom_range(1, 6);
					end
					run_left--;
					hold = run_hold;
				end
			endcase
			phase_cnt++;
			result_stall <= hold;
		end
	end

	// one byte transaction, with a random gap between bursts
	task automatic send_item(input logic [7:0] value, input logic final_byte);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_data  <= '{data_byte: value, last_byte: final_byte};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	// send the assembled block, last_byte on its final byte
	task automatic send_pending();
		int i;
		for (i = 0; i < pending.size(); i++)
			send_item(pending[i], i == pending.size() - 1);
		bytes_sent += pending.size();
		blocks_sent++;
		pending.delete();
	endtask

	// hold off until every expected line report has come
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			pending.push_back(s[i]);
	endtask

	// first count characters of table name k
	task automatic push_name(input int k, input int count);
		int i;
		int nlen;
		nlen = NAME_LEN[k];
		for (i = 0; i < count; i++)
			pending.push_back(NAME_TABLE[k][8*(nlen-1-i) +: 8]);
	endtask

	task automatic push_bytes(input int count, input int lo, input int hi);
		int i;
		for (i = 0; i < count; i++)
			pending.push_back(8'($urandom_range(lo, hi)));
	endtask

	// one header line: known name with a value, broken name, noise or empty
	task automatic build_line();
		int r;
		int k;
		int n;
		int i;
		r = $urandom_range(0, 9);
		if ($urandom_range(0, 1))
			k = $urandom_range(0, NAME_COUNT - 1);
		else
			k = $urandom_range(0, 1) ? IDX_CONTENT_LENGTH : IDX_STATUS;
		if (r <= 5) begin
			push_name(k, NAME_LEN[k]);
			if (k == IDX_CONTENT_LENGTH || k == IDX_STATUS || $urandom_range(0, 3) == 0) begin
				// blanks, sign, digits, then maybe trailing junk
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 4))
						0:       pending.push_back(CH_SP);
						1:       pending.push_back(CH_TAB);
						2:       pending.push_back(CH_VT);
						3:       pending.push_back(CH_FF);
						default: pending.push_back(CH_CR);
					endcase
				end
				case ($urandom_range(0, 5))
					0: pending.push_back(CH_PLUS);
					1: pending.push_back(CH_MINUS);
					2: begin
						pending.push_back(CH_MINUS);
						pending.push_back(CH_PLUS);
					end
					default: begin
					end
				endcase
				case ($urandom_range(0, 9))
					0:       push_text("4294967295");
					1:       push_text("4294967296");
					2:       push_bytes($urandom_range(10, 14), CH_ZERO, CH_NINE);
					default: push_bytes($urandom_range(0, 5), CH_ZERO, CH_NINE);
				endcase
				if ($urandom_range(0, 2) == 0)
					push_bytes($urandom_range(1, 4), 8'h20, 8'h7E);
			end else begin
				push_bytes($urandom_range(0, 20), 8'h20, 8'h7E);
			end
		end else if (r <= 7) begin
			// name broken partway through
			push_name(k, $urandom_range(0, NAME_LEN[k] - 1));
			push_bytes(1, 8'h20, 8'h7E);
			push_bytes($urandom_range(0, 10), 8'h20, 8'h7E);
		end else if (r == 8) begin
			push_bytes($urandom_range(0, 40), 0, 255);
		end
		if ($urandom_range(0, 3) != 0)
			pending.push_back(CH_CR);
		pending.push_back(CH_LF);
	endtask

	// a block of lines, ending on a newline, mid line or on a name
	task automatic build_block(input int min_bytes);
		int         cut;
		int         k;
		logic [7:0] dropped;
		pending.delete();
		build_line();
		while (pending.size() < min_bytes) build_line();
		case ($urandom_range(0, 3))
			0: begin
				cut = $urandom_range(1, pending.size());
				while (pending.size() > cut) dropped = pending.pop_back();
			end
			1: begin
				k = $urandom_range(0, NAME_COUNT - 1);
				push_name(k, NAME_LEN[k]);
			end
			default: begin
			end
		endcase
	endtask

	// stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line, extreme bytes, newline as the final byte
		pending.push_back(CH_LF);
		pending.push_back(8'h00);
		pending.push_back(8'hFF);
		pending.push_back(CH_LF);
		send_pending();
		// name completed on the final byte gives no match
		push_text("Cookie:");
		send_pending();
		// final byte is a carriage return after a value
		push_text("Range: 5");
		pending.push_back(CH_CR);
		send_pending();
		// one byte block
		pending.push_back(8'hFF);
		send_pending();
		wait_drained();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			build_block($urandom_range(1, 120));
			send_pending();
			if (blocks_sent % 9 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("http_header_line_parser_unit regression: pass");
		else
			$display("http_header_line_parser_unit regression: fail");
		$finish;
	end

endmodule

FILE: http_header_line_parser_unit.f
+incdir+hdl
hdl/hhlp_pkg.sv
hdl/hhlp_front.sv
hdl/hhlp_queue.sv
hdl/hhlp_back.sv
hdl/http_header_line_parser_unit.sv
hdl/hhlp_checker.sv
tb/sv/header_result_checker.sv
tb/sv/http_header_line_parser_unit_tb.sv
